@@ src/gba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gba_pkg
// Shared constants for the glyph bitmap address pipeline: geometry,
// field widths, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package gba_pkg;

  // Font store geometry
  localparam int PAGE_BYTES  = 2048;
  localparam int BLOCK_BYTES = 1024;

  // Field widths
  localparam int CODE_W = 16;
  localparam int COL_W  = 8;
  localparam int PAGE_W = 24;
  localparam int GEO_W  = 7;
  localparam int OFF_W  = 36;
  localparam int GB_W   = 10;
  localparam int ST_W   = 2;

  // Internal widths
  localparam int SIZE_W   = 11;                       // (width/8) * height
  localparam int IDX_W    = 16;                       // glyph index, never above 65024
  localparam int PB_W     = $clog2(BLOCK_BYTES + 1);  // glyphs per block
  localparam int DIV_STEP = 3;                        // quotient bits per divider stage

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_FONT_PRESENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LATIN_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_PAGE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd6;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_FONT = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

  // Row layouts
  localparam logic [COL_W-1:0] JIS_COL_LO = 8'h21;
  localparam logic [COL_W-1:0] JIS_COL_HI = 8'h7e;
  localparam logic [COL_W-1:0] JIS_ROW    = 8'h5e;
  localparam logic [COL_W-1:0] LAT_COL_LO = 8'h01;
  localparam logic [COL_W-1:0] LAT_COL_HI = 8'hfe;
  localparam logic [COL_W-1:0] LAT_ROW    = 8'hfe;

endpackage
`default_nettype wire

@@ src/gba_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gba_in_if / gba_out_if
// Valid/ready channels for character codes in and glyph addresses out.
// ----------------------------------------------------------------------------
interface gba_in_if;
  import gba_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] char_code_in;

  modport source (output valid, output char_code_in, input ready);
  modport sink   (input valid, input char_code_in, output ready);
endinterface

interface gba_out_if;
  import gba_pkg::*;

  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] byte_offset;
  logic [GB_W-1:0]  glyph_bytes;
  logic [ST_W-1:0]  status;

  modport source (output valid, output byte_offset, output glyph_bytes, output status,
                  input ready);
  modport sink   (input valid, input byte_offset, input glyph_bytes, input status,
                  output ready);
endinterface
`default_nettype wire

@@ src/glyph_bitmap_address.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_bitmap_address
// Maps a two-byte character code to the byte offset and size of its glyph
// bitmap: range checks, glyph index, two pipelined long divisions, offset sum.
// ----------------------------------------------------------------------------
// Pipeline: 2 index stages, 4 stages for glyphs-per-block, 6 stages for the
//   block/slot split and 2 offset stages.
// Throughput: one code per cycle; the whole pipe holds while a result waits.
// Reset: synchronous active-low; clears all stage valids and loads the
//   register defaults (no font, JIS rows, 8x16 glyphs, codes and page 0).
module glyph_bitmap_address (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gba_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gba_pkg::CFG_DATA_W-1:0] cfg_data,
  gba_in_if.sink                         in_ch,
  gba_out_if.source                      out_ch
);
  import gba_pkg::*;

  localparam int D1_ST = (PB_W + DIV_STEP - 1) / DIV_STEP;   // per-block divide
  localparam int D2_ST = (IDX_W + DIV_STEP - 1) / DIV_STEP;  // index divide
  localparam int NDIV  = D1_ST + D2_ST;
  localparam int PROD_W = 18;                                 // signed row term
  localparam logic [PB_W-1:0] BLK_VEC = PB_W'(BLOCK_BYTES);

  // Stage 1: raw compares and products
  typedef struct packed {
    logic                     no_font;
    logic                     out_range;
    logic [SIZE_W-1:0]        size;
    logic signed [PROD_W-1:0] row_term;
    logic signed [COL_W:0]    col_diff;
    logic [PAGE_W-1:0]        page;
  } s1_t;

  // Stage 2 and divider stages
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SIZE_W-1:0] size;
    logic [IDX_W-1:0]  idx;
    logic [PAGE_W-1:0] page;
    logic [PB_W-1:0]   per_blk;
    logic [SIZE_W:0]   rem1;
    logic [PB_W:0]     rem2;
    logic [IDX_W-1:0]  quo;
  } pl_t;

  // Offset stage
  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic [SIZE_W-1:0]        size;
    logic [OFF_W-1:0]         base;
    logic [PB_W+SIZE_W-1:0]   slot_off;
  } m_t;

  typedef struct packed {
    logic [OFF_W-1:0] byte_offset;
    logic [GB_W-1:0]  glyph_bytes;
    logic [ST_W-1:0]  status;
  } res_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic              font_present_r;
  logic              latin_mode_r;
  logic [CODE_W-1:0] start_code_r;
  logic [CODE_W-1:0] end_code_r;
  logic [PAGE_W-1:0] font_page_r;
  logic [GEO_W-1:0]  glyph_width_r;
  logic [GEO_W-1:0]  glyph_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_present_r <= 1'b0;
      latin_mode_r   <= 1'b0;
      start_code_r   <= '0;
      end_code_r     <= '0;
      font_page_r    <= '0;
      glyph_width_r  <= GEO_W'(8);
      glyph_height_r <= GEO_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FONT_PRESENT: font_present_r <= cfg_data[0];
        CFG_LATIN_MODE:   latin_mode_r   <= cfg_data[0];
        CFG_START_CODE:   start_code_r   <= cfg_data[CODE_W-1:0];
        CFG_END_CODE:     end_code_r     <= cfg_data[CODE_W-1:0];
        CFG_FONT_PAGE:    font_page_r    <= cfg_data[PAGE_W-1:0];
        CFG_GLYPH_WIDTH:  glyph_width_r  <= cfg_data[GEO_W-1:0];
        CFG_GLYPH_HEIGHT: glyph_height_r <= cfg_data[GEO_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: one global advance; the output register parts the sides.
  // --------------------------------------------------------------------------
  logic out_v_r;
  res_t out_r;
  logic adv;

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  // --------------------------------------------------------------------------
  // Stage 1: column/range checks, glyph size, row distance times row length
  // --------------------------------------------------------------------------
  logic                     s1_v_r;
  s1_t                      s1_r;
  s1_t                      s1_nxt;
  logic [COL_W-1:0]         col;
  logic [COL_W-1:0]         col_lo;
  logic [COL_W-1:0]         col_hi;
  logic [COL_W-1:0]         row_len;
  logic signed [COL_W:0]    row_diff;
  logic signed [PROD_W-1:0] row_diff_ext;

  always_comb begin
    col     = in_ch.char_code_in[COL_W-1:0];
    col_lo  = latin_mode_r ? LAT_COL_LO : JIS_COL_LO;
    col_hi  = latin_mode_r ? LAT_COL_HI : JIS_COL_HI;
    row_len = latin_mode_r ? LAT_ROW : JIS_ROW;

    row_diff     = $signed({1'b0, in_ch.char_code_in[CODE_W-1:COL_W]})
                 - $signed({1'b0, start_code_r[CODE_W-1:COL_W]});
    row_diff_ext = row_diff;

    s1_nxt.no_font   = !font_present_r;
    s1_nxt.out_range = (in_ch.char_code_in < start_code_r)
                    || (in_ch.char_code_in > end_code_r)
                    || (col < col_lo) || (col > col_hi);
    // bytes per row (up to 15) times rows (up to 127), full width operands
    s1_nxt.size      = {{(SIZE_W-GEO_W+3){1'b0}}, glyph_width_r[GEO_W-1:3]}
                     * {{(SIZE_W-GEO_W){1'b0}}, glyph_height_r};
    s1_nxt.row_term  = row_diff_ext
                     * $signed({{(PROD_W-COL_W){1'b0}}, row_len});
    s1_nxt.col_diff  = $signed({1'b0, col}) - $signed({1'b0, start_code_r[COL_W-1:0]});
    s1_nxt.page      = font_page_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: glyph index and status
  // --------------------------------------------------------------------------
  logic                v_r  [NDIV+1];
  pl_t                 pl_r [NDIV+1];
  pl_t                 s2_nxt;
  logic signed [PROD_W-1:0] idx_s;
  logic                bad_size;

  always_comb begin
    idx_s    = s1_r.row_term + PROD_W'(s1_r.col_diff);
    bad_size = (s1_r.size == '0) || ({1'b0, s1_r.size} > (SIZE_W+1)'(BLOCK_BYTES));

    s2_nxt         = '0;
    s2_nxt.size    = s1_r.size;
    s2_nxt.idx     = idx_s[IDX_W-1:0];
    s2_nxt.page    = s1_r.page;
    priority if (s1_r.no_font) begin
      s2_nxt.status = ST_NO_FONT;
    end else if (s1_r.out_range || bad_size || idx_s < 0) begin
      s2_nxt.status = ST_RANGE;
    end else begin
      s2_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r[0] <= s2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages, DIV_STEP restoring steps each.
  // First D1_ST: glyphs per block = BLOCK_BYTES / size.
  // Next D2_ST: idx / per_blk -> block number (quo) and slot (rem2).
  // A zero divisor only happens on items already marked out of range or no font.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    pl_t div_nxt;

    always_comb begin
      pl_t             p;
      int              pos;
      logic [SIZE_W:0] t1;
      logic [PB_W:0]   t2;

      p  = pl_r[k];
      t1 = '0;
      t2 = '0;
      for (int j = 0; j < DIV_STEP; j++) begin
        if (k < D1_ST) begin
          pos = PB_W - 1 - k * DIV_STEP - j;
          if (pos >= 0) begin
            t1 = {p.rem1[SIZE_W-1:0], BLK_VEC[pos]};
            if (t1 >= {1'b0, p.size}) begin
              t1             = t1 - {1'b0, p.size};
              p.per_blk[pos] = 1'b1;
            end else begin
              p.per_blk[pos] = 1'b0;
            end
            p.rem1 = t1;
          end
        end else begin
          pos = IDX_W - 1 - (k - D1_ST) * DIV_STEP - j;
          if (pos >= 0) begin
            t2 = {p.rem2[PB_W-1:0], p.idx[pos]};
            if (t2 >= {1'b0, p.per_blk}) begin
              t2         = t2 - {1'b0, p.per_blk};
              p.quo[pos] = 1'b1;
            end else begin
              p.quo[pos] = 1'b0;
            end
            p.rem2 = t2;
          end
        end
      end
      div_nxt = p;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pl_r[k+1] <= div_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Offset stage: page and block base, slot times glyph size
  // --------------------------------------------------------------------------
  logic m_v_r;
  m_t   m_r;
  m_t   m_nxt;

  always_comb begin
    m_nxt.status   = pl_r[NDIV].status;
    m_nxt.size     = pl_r[NDIV].size;
    m_nxt.base     = OFF_W'(pl_r[NDIV].page) * OFF_W'(PAGE_BYTES)
                   + OFF_W'(pl_r[NDIV].quo) * OFF_W'(BLOCK_BYTES);
    m_nxt.slot_off = pl_r[NDIV].rem2[PB_W-1:0] * pl_r[NDIV].size;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= v_r[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r <= m_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: final sum, zeroed fields when status is not ok
  // --------------------------------------------------------------------------
  res_t out_nxt;

  always_comb begin
    out_nxt.status = m_r.status;
    if (m_r.status == ST_OK) begin
      out_nxt.byte_offset = m_r.base + OFF_W'(m_r.slot_off);
      out_nxt.glyph_bytes = m_r.size[GB_W-1:0];  // a full 1024-byte glyph wraps to 0
    end else begin
      out_nxt.byte_offset = '0;
      out_nxt.glyph_bytes = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.byte_offset = out_r.byte_offset;
  assign out_ch.glyph_bytes = out_r.glyph_bytes;
  assign out_ch.status      = out_r.status;

endmodule
`default_nettype wire

@@ dv/glyph_bitmap_address_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_bitmap_address_test
// Self-checking bench for the glyph bitmap address pipeline. A directed
// table drives the no-font, out-of-range, bad-geometry and negative-index
// cases and the field extremes. Register settings then change at random
// phase by phase, with mostly in-font codes. Every result is compared
// against a typed-in result or the in-bench address calculator, field by field, in order.
// ----------------------------------------------------------------------------
module glyph_bitmap_address_test;
  import gba_pkg::*;

  localparam int  HALF_PERIOD = 10;
  localparam int  RESET_CYCLES = 6;
  localparam int  PHASES = 16;
  localparam int  CODES_PER_PHASE = 100;
  localparam int  SETTLE_CYCLES = 40;         // pipe is 14 deep, leave slack
  localparam longint WATCHDOG_NS = 5_000_000;
  localparam int  PLAN_ROWS = 42;

  // One glyph lookup result as the output channel carries it.
  typedef struct packed {
    logic [OFF_W-1:0] byte_offset;
    logic [GB_W-1:0]  glyph_bytes;
    logic [ST_W-1:0]  status;
  } glyph_res_t;

  // Expected result plus the code that caused it, for the mismatch report.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    glyph_res_t        res;
  } lookup_t;

  // Directed table: a register write, a code checked by the calculator,
  // or a code whose result is typed in here.
  typedef enum logic [1:0] {
    STEP_CFG,
    STEP_CODE,
    STEP_FIXED
  } step_kind_t;

  typedef struct packed {
    step_kind_t            kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [CODE_W-1:0]     code;
    logic [OFF_W-1:0]      byte_offset;
    logic [GB_W-1:0]       glyph_bytes;
    logic [ST_W-1:0]       status;
  } step_t;

  // Receiver behavior, picked anew at random whenever the current pattern runs out.
  typedef enum logic [1:0] {
    RX_OPEN,      // always ready
    RX_COIN,      // ready half of the time
    RX_STARVED,   // ready at random, with a chance of one in eight
    RX_THIRDS     // regular pattern, ready two thirds of the time
  } rx_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  gba_in_if  in_ch ();
  gba_out_if out_ch ();

  glyph_bitmap_address dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Shadow copy of the register file, updated as each write is driven.
  logic              font_on;
  logic              latin_rows;
  logic [CODE_W-1:0] first_code;
  logic [CODE_W-1:0] last_code;
  logic [PAGE_W-1:0] page_base;
  logic [GEO_W-1:0]  width_px;
  logic [GEO_W-1:0]  height_px;

  lookup_t    pending_glyphs[$];   // results still owed by the block, oldest first
  step_t      plan [PLAN_ROWS];
  bit         fixed_now;           // item on the input carries a typed result
  glyph_res_t fixed_res;
  int         burst_left;
  rx_mode_t   stall_mode;
  int         stall_left;
  int         errors;
  int         codes_sent;
  int         results_seen;
  int         settings_run;
  int         seen_ok;
  int         seen_no_font;
  int         seen_range;

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Address calculator: status checks in priority order, then glyph index,
  // then block/slot split of the index.
  // --------------------------------------------------------------------------
  function automatic glyph_res_t locate_glyph(input logic [CODE_W-1:0] code);
    glyph_res_t r;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] col_lo;
    logic [COL_W-1:0] col_hi;
    int row_len;
    int size;
    int per_block;
    int idx;
    longint off;
    r = '0;
    col = code[COL_W-1:0];
    col_lo = latin_rows ? LAT_COL_LO : JIS_COL_LO;
    col_hi = latin_rows ? LAT_COL_HI : JIS_COL_HI;
    row_len = int'(latin_rows ? LAT_ROW : JIS_ROW);
    if (!font_on) begin
      r.status = ST_NO_FONT;
      return r;
    end
    if (code < first_code || code > last_code || col < col_lo || col > col_hi) begin
      r.status = ST_RANGE;
      return r;
    end
    // width counts whole bytes only; size 0 or over a block cannot be packed
    size = (int'(width_px) / 8) * int'(height_px);
    if (size == 0 || size > BLOCK_BYTES) begin
      r.status = ST_RANGE;
      return r;
    end
    // a start column beyond the code's column on an earlier row can go negative
    idx = (int'(code[15:8]) - int'(first_code[15:8])) * row_len
        + (int'(col) - int'(first_code[7:0]));
    if (idx < 0) begin
      r.status = ST_RANGE;
      return r;
    end
    per_block = BLOCK_BYTES / size;
    off = longint'(page_base) * PAGE_BYTES
        + longint'(idx / per_block) * BLOCK_BYTES
        + longint'(idx % per_block) * size;
    r.byte_offset = off[OFF_W-1:0];
    r.glyph_bytes = size[GB_W-1:0];
    r.status = ST_OK;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Register write; the task then drops cfg_we and waits for a further falling
  // edge, so cfg_we never toggles twice within a time step.
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FONT_PRESENT: font_on    = val[0];
      CFG_LATIN_MODE:   latin_rows = val[0];
      CFG_START_CODE:   first_code = val[CODE_W-1:0];
      CFG_END_CODE:     last_code  = val[CODE_W-1:0];
      CFG_FONT_PAGE:    page_base  = val[PAGE_W-1:0];
      CFG_GLYPH_WIDTH:  width_px   = val[GEO_W-1:0];
      CFG_GLYPH_HEIGHT: height_px  = val[GEO_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them (often none).
  // Called and returns at a falling edge; valid stays high across a burst.
  // --------------------------------------------------------------------------
  task automatic send_code(input logic [CODE_W-1:0] code, input bit fixed,
                           input glyph_res_t res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    fixed_now = fixed;
    fixed_res = res;
    in_ch.valid        <= 1'b1;
    in_ch.char_code_in <= code;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    codes_sent++;
  endtask

  // Stop sending and wait for every owed result; the pipe is then empty.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_glyphs.size() != 0);
    burst_left = 0;
  endtask

  // --------------------------------------------------------------------------
  // One register setting per phase. The first phases pin the extremes;
  // later ones are mostly sane fonts with some junk geometry and ranges.
  // --------------------------------------------------------------------------
  task automatic pick_setting(input int phase);
    logic [CODE_W-1:0] s_code;
    logic [CODE_W-1:0] e_code;
    logic [PAGE_W-1:0] page;
    logic [GEO_W-1:0]  w;
    logic [GEO_W-1:0]  h;
    logic              latin;
    logic              font;
    logic [COL_W-1:0]  lo;
    logic [COL_W-1:0]  hi;
    int span;
    font  = ($urandom_range(0, 7) != 0);
    latin = 1'($urandom_range(0, 1));
    lo = latin ? LAT_COL_LO : JIS_COL_LO;
    hi = latin ? LAT_COL_HI : JIS_COL_HI;
    if ($urandom_range(0, 9) == 0) begin
      s_code = 16'($urandom);
      e_code = 16'($urandom);
    end else begin
      s_code = {8'($urandom_range(0, 255)), 8'($urandom_range(lo, hi))};
      span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4000);
      e_code = (int'(s_code) + span > 65535) ? 16'hffff : 16'(int'(s_code) + span);
    end
    page = 24'($urandom);
    w = ($urandom_range(0, 3) != 0) ? 7'(8 * $urandom_range(1, 8)) : 7'($urandom_range(0, 127));
    h = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(1, 64)) : 7'($urandom_range(0, 127));
    case (phase)
      0: begin                      // largest page, whole code space, 64x64
        font = 1'b1; latin = 1'b1; s_code = 16'h0000; e_code = 16'hffff;
        page = 24'hffffff; w = 7'd64; h = 7'd64;
      end
      1: begin                      // smallest glyph, full JIS table
        font = 1'b1; latin = 1'b0; s_code = 16'h2121; e_code = 16'h7e7e;
        page = 24'h000000; w = 7'd8; h = 7'd1;
      end
      2: begin                      // one glyph per block, tallest height
        font = 1'b1; w = 7'd64; h = 7'd127;
      end
      3: begin                      // largest width field value (15 bytes per row), 8 rows high
        font = 1'b1; w = 7'd127; h = 7'd8;
      end
      default: ;
    endcase
    write_reg(CFG_FONT_PRESENT, CFG_DATA_W'(font));
    write_reg(CFG_LATIN_MODE,   CFG_DATA_W'(latin));
    write_reg(CFG_START_CODE,   CFG_DATA_W'(s_code));
    write_reg(CFG_END_CODE,     CFG_DATA_W'(e_code));
    write_reg(CFG_FONT_PAGE,    page);
    write_reg(CFG_GLYPH_WIDTH,  CFG_DATA_W'(w));
    write_reg(CFG_GLYPH_HEIGHT, CFG_DATA_W'(h));
    settings_run++;
  endtask

  // Mostly codes inside the font with a legal column; some edges, some noise.
  function automatic logic [CODE_W-1:0] pick_code();
    int roll;
    logic [COL_W-1:0] lo;
    logic [COL_W-1:0] hi;
    roll = $urandom_range(0, 99);
    lo = latin_rows ? LAT_COL_LO : JIS_COL_LO;
    hi = latin_rows ? LAT_COL_HI : JIS_COL_HI;
    if (roll < 8)
      return 16'($urandom);
    if (roll < 14) begin
      case ($urandom_range(0, 3))
        0:       return first_code;
        1:       return last_code;
        2:       return first_code - 16'd1;
        default: return last_code + 16'd1;
      endcase
    end
    return {8'($urandom_range(first_code[15:8], last_code[15:8])),
            8'($urandom_range(lo, hi))};
  endfunction

  task automatic flag_field(input string name, input logic [CODE_W-1:0] code,
                            input logic [OFF_W-1:0] want, input logic [OFF_W-1:0] got);
    if (want != got) begin
      errors++;
      $display("%0t: code 0x%04h %s expected 0x%0h actual 0x%0h",
               $time, code, name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver stall pattern, independent of the sender.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(30, 300);
    end
    stall_left--;
    case (stall_mode)
      RX_OPEN:    out_ch.ready <= 1'b1;
      RX_COIN:    out_ch.ready <= ($urandom_range(0, 1) == 1);
      RX_STARVED: out_ch.ready <= ($urandom_range(0, 7) == 0);
      default:    out_ch.ready <= (stall_left % 3 != 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Transfer monitor: log each accepted code, check each accepted result
  // against the oldest owed one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    lookup_t   owed;
    glyph_res_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        owed.code = in_ch.char_code_in;
        owed.res  = fixed_now ? fixed_res : locate_glyph(in_ch.char_code_in);
        pending_glyphs.push_back(owed);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.byte_offset, out_ch.glyph_bytes, out_ch.status};
        results_seen++;
        case (got.status)
          ST_OK:      seen_ok++;
          ST_NO_FONT: seen_no_font++;
          default:    seen_range++;
        endcase
        if (pending_glyphs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result offset 0x%0h bytes %0d status %0d",
                   $time, got.byte_offset, got.glyph_bytes, got.status);
        end else begin
          owed = pending_glyphs.pop_front();
          flag_field("byte_offset", owed.code, owed.res.byte_offset, got.byte_offset);
          flag_field("glyph_bytes", owed.code, OFF_W'(owed.res.glyph_bytes),
                     OFF_W'(got.glyph_bytes));
          flag_field("status", owed.code, OFF_W'(owed.res.status), OFF_W'(got.status));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.char_code_in = '0;
    out_ch.ready = 1'b0;
    stall_mode = RX_OPEN;
    stall_left = 0;
    burst_left = 0;
    fixed_now = 1'b0;
    fixed_res = '0;
    errors = 0;
    codes_sent = 0;
    results_seen = 0;
    settings_run = 0;
    seen_ok = 0;
    seen_no_font = 0;
    seen_range = 0;
    // register defaults after reset
    font_on = 1'b0;
    latin_rows = 1'b0;
    first_code = '0;
    last_code = '0;
    page_base = '0;
    width_px = 7'd8;
    height_px = 7'd16;

    // Directed table. Typed results only where obvious from the rules.
    plan = '{
      // reset state: no font selected
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h2121, 36'h0, 10'd0, ST_NO_FONT},
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'hffff, 36'h0, 10'd0, ST_NO_FONT},
      '{STEP_CFG,   CFG_FONT_PRESENT, 24'd1, 16'h0000, 36'h0, 10'd0, ST_OK},
      // column 0x00 never valid in JIS rows
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h0000, 36'h0, 10'd0, ST_RANGE},
      '{STEP_CFG,   CFG_START_CODE, 24'h2121, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_CFG,   CFG_END_CODE,   24'h7e7e, 16'h0000, 36'h0, 10'd0, ST_OK},
      // first two glyphs of an 8x16 JIS font at page 0
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h2121, 36'd0,  10'd16, ST_OK},
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h2122, 36'd16, 10'd16, ST_OK},
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h2120, 36'h0, 10'd0, ST_RANGE},
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h217f, 36'h0, 10'd0, ST_RANGE},
      '{STEP_CODE,  CFG_FONT_PRESENT, 24'd0, 16'h7e7e, 36'h0, 10'd0, ST_OK},
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h7e7f, 36'h0, 10'd0, ST_RANGE},
      '{STEP_CODE,  CFG_FONT_PRESENT, 24'd0, 16'h2221, 36'h0, 10'd0, ST_OK},
      // top page, 64x64 glyphs: two per block
      '{STEP_CFG,   CFG_FONT_PAGE,    24'hffffff, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_CFG,   CFG_GLYPH_WIDTH,  24'd64, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_CFG,   CFG_GLYPH_HEIGHT, 24'd64, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h2121, 36'h7_ffff_f800, 10'd512, ST_OK},
      '{STEP_CODE,  CFG_FONT_PRESENT, 24'd0, 16'h2122, 36'h0, 10'd0, ST_OK},
      '{STEP_CODE,  CFG_FONT_PRESENT, 24'd0, 16'h2123, 36'h0, 10'd0, ST_OK},
      // width under one byte: zero-size glyph
      '{STEP_CFG,   CFG_GLYPH_WIDTH,  24'd7, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h2121, 36'h0, 10'd0, ST_RANGE},
      // glyph larger than a block
      '{STEP_CFG,   CFG_GLYPH_WIDTH,  24'd127, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_CFG,   CFG_GLYPH_HEIGHT, 24'd127, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h2121, 36'h0, 10'd0, ST_RANGE},
      // Latin rows, 1-byte glyphs over the whole code space
      '{STEP_CFG,   CFG_LATIN_MODE,   24'd1, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_CFG,   CFG_GLYPH_WIDTH,  24'd8, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_CFG,   CFG_GLYPH_HEIGHT, 24'd1, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_CFG,   CFG_START_CODE,   24'h0001, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_CFG,   CFG_END_CODE,     24'hffff, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_CFG,   CFG_FONT_PAGE,    24'h0, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h0001, 36'd0, 10'd1, ST_OK},
      '{STEP_CODE,  CFG_FONT_PRESENT, 24'd0, 16'h00fe, 36'h0, 10'd0, ST_OK},
      '{STEP_CODE,  CFG_FONT_PRESENT, 24'd0, 16'h0101, 36'h0, 10'd0, ST_OK},
      '{STEP_CODE,  CFG_FONT_PRESENT, 24'd0, 16'hfffe, 36'h0, 10'd0, ST_OK},
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h00ff, 36'h0, 10'd0, ST_RANGE},
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h0100, 36'h0, 10'd0, ST_RANGE},
      // start column past the JIS range: next row's index goes negative
      '{STEP_CFG,   CFG_LATIN_MODE,   24'd0, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_CFG,   CFG_START_CODE,   24'h21ff, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h2221, 36'h0, 10'd0, ST_RANGE},
      '{STEP_CODE,  CFG_FONT_PRESENT, 24'd0, 16'h227e, 36'h0, 10'd0, ST_OK},
      // font dropped: no-font wins over everything
      '{STEP_CFG,   CFG_FONT_PRESENT, 24'd0, 16'h0000, 36'h0, 10'd0, ST_OK},
      '{STEP_FIXED, CFG_FONT_PRESENT, 24'd0, 16'h3030, 36'h0, 10'd0, ST_NO_FONT}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        wait_drained();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_code(plan[i].code, plan[i].kind == STEP_FIXED,
                  '{plan[i].byte_offset, plan[i].glyph_bytes, plan[i].status});
      end
    end

    // Random phases; the odd mid-phase pause lets the pipe run dry.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      pick_setting(phase);
      repeat (CODES_PER_PHASE) begin
        if ($urandom_range(0, 299) == 0)
          wait_drained();
        send_code(pick_code(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d codes under %0d random register settings plus the directed table.",
             codes_sent, settings_run);
    $display("Checked %0d results: %0d ok, %0d no font, %0d out of range.",
             results_seen, seen_ok, seen_no_font, seen_range);
    if (errors == 0) begin
      $display("glyph_bitmap_address verification clean");
    end else begin
      $display("glyph_bitmap_address verification failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #(WATCHDOG_NS);
    $display("glyph_bitmap_address verification failed");
    $finish;
  end

endmodule
